/* sv/sprite_billboard_projector_macros.svh */
// assertion macros for the sprite billboard projector
`ifndef SPRITE_BILLBOARD_PROJECTOR_MACROS_SVH
`define SPRITE_BILLBOARD_PROJECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define SBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define SBP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SBP_ASSERT(name, prop, msg)
`define SBP_ASSERT_NEVER(name, cond, msg)

`endif

`endif

/* sv/sbp_pkg.sv */
// shared types, constants and helpers of the sprite billboard projector
`timescale 1ns / 1ps

package sbp_pkg;

  localparam int TILE_PIXELS = 64;

  // pipelined divider: 48-bit dividend, 32-bit divisor, quotient saturates at 16 bits
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 32;
  localparam int DIV_Q_W = 16;
  localparam int DIV_LAT = DIV_Q_W + 1;

  // three divider spans plus the surrounding stages
  localparam int PIPE_LAT = 3 * DIV_LAT + 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_DIST = 3'd0,
    REG_HALF_W     = 3'd1,
    REG_HALF_H     = 3'd2,
    REG_SCREEN_W   = 3'd3,
    REG_SCREEN_H   = 3'd4,
    REG_TEX_W      = 3'd5,
    REG_TEX_H      = 3'd6
  } sbp_reg_e;

  typedef struct packed {
    logic [31:0] plane_distance;
    logic [11:0] half_screen_width;
    logic [11:0] half_screen_height;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [12:0] texture_width;
    logic [12:0] texture_height;
  } sbp_cfg_t;

  localparam sbp_cfg_t CFG_RESET = '{
    plane_distance:     32'd36306944,
    half_screen_width:  12'd320,
    half_screen_height: 12'd240,
    screen_width:       13'd640,
    screen_height:      13'd480,
    texture_width:      13'd64,
    texture_height:     13'd64
  };

  typedef struct packed {
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_depth;
    logic [11:0]        pixel_column;
    logic [11:0]        pixel_row;
  } sbp_req_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [15:0] center_x;
    logic [15:0]        sprite_height;
    logic [15:0]        sprite_width;
    logic [11:0]        start_x;
    logic [11:0]        end_x;
    logic [11:0]        start_y;
    logic [11:0]        end_y;
    logic [11:0]        texel_x;
    logic [11:0]        texel_y;
  } sbp_res_t;

  // per-request sideband carried alongside the dividers
  typedef struct packed {
    logic               ok;
    logic [11:0]        col;
    logic [11:0]        row;
    logic               cx_neg;
    logic signed [15:0] cx;
    logic [15:0]        h;
    logic [15:0]        w;
    logic signed [17:0] top;
    logic signed [17:0] left;
    logic [11:0]        ty;
  } sbp_side_t;

  function automatic logic [12:0] size_nz(logic [12:0] s);
    return (s == '0) ? 13'd1 : s;
  endfunction

  // size - 1, floored at 0 and capped at 4095
  function automatic logic [11:0] size_lim(logic [12:0] s);
    logic [12:0] m;
    m = s - 13'd1;
    if (s == '0) begin
      return 12'd0;
    end else if (m[12]) begin
      return 12'hFFF;
    end
    return m[11:0];
  endfunction

  function automatic logic [11:0] clamp_edge(logic signed [17:0] v, logic [11:0] lim);
    if (v < 0) begin
      return 12'd0;
    end else if (v > $signed({6'b0, lim})) begin
      return lim;
    end
    return v[11:0];
  endfunction

  function automatic logic [11:0] clamp_quo(logic [15:0] q, logic [11:0] lim);
    return (q > {4'b0, lim}) ? lim : q[11:0];
  endfunction

endpackage

/* sv/sprite_billboard_projector.sv */
// top level of the sprite billboard projector
`timescale 1ns / 1ps
//
// Projects a camera-space sprite for one screen pixel per request.
// Request channel: req_i is taken at a clock edge where start_i is high and
// busy_o is low. busy_o stays low, so a request can be issued every cycle.
// Result channel: res_o is shown for exactly one cycle with res_valid_o high.
// Results come back in request order. Throughput is one request per cycle.
// Latency is set by three chained spans of 17-stage dividers (depth;
// texture aspect and texel row; texel column), one quotient bit per stage
// after the first, plus the multiply, setup and clamp stages between them.
// A depth of zero or less gives a result with valid_res low and all fields zero.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// clock edge; write only while no request is in flight.
// Reset clears the valid bits and config to defaults, dropping every request in
// flight. The receiver cannot stall: each result is taken in its cycle.

`include "sprite_billboard_projector_macros.svh"

module sprite_billboard_projector import sbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  sbp_req_t              req_i,
  output logic                  busy_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  res_valid_o,
  output sbp_res_t              res_o
);

  sbp_cfg_t cfg;

  sbp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  logic [12:0]        tw_eff, th_eff;
  logic signed [13:0] tw_s, th_s;
  logic signed [12:0] hw_s;
  logic [11:0]        tx_lim, ty_lim, wx_lim, wy_lim;

  assign tw_eff = size_nz(cfg.texture_width);
  assign th_eff = size_nz(cfg.texture_height);
  assign tw_s   = $signed({1'b0, tw_eff});
  assign th_s   = $signed({1'b0, th_eff});
  assign hw_s   = $signed({1'b0, cfg.half_screen_width});
  assign tx_lim = size_lim(tw_eff);
  assign ty_lim = size_lim(th_eff);
  assign wx_lim = size_lim(cfg.screen_width);
  assign wy_lim = size_lim(cfg.screen_height);

  assign busy_o = 1'b0;

  // stage 0: request capture
  logic     s0_vld_q;
  sbp_req_t s0_req_q;

  // stage 1: center numerator product, height numerator
  logic               s1_vld_q, s1_ok_q, s1_ok_d;
  logic [11:0]        s1_col_q, s1_row_q;
  logic [31:0]        s1_d_q;
  logic signed [32:0] s0_sum;
  logic signed [45:0] s1_prod_q, s1_prod_d;
  logic [47:0]        s1_na_q, s1_na_d;

  assign s1_ok_d   = s0_req_q.rel_depth > 0;
  assign s0_sum    = 33'(s0_req_q.rel_x) + 33'(s0_req_q.rel_depth);
  assign s1_prod_d = 46'(s0_sum) * 46'(hw_s);
  assign s1_na_d   = 48'(cfg.plane_distance) * 48'(TILE_PIXELS);

  // stage 2: magnitude of the center numerator
  logic        s2_vld_q;
  sbp_side_t   s2_side_q, s2_side_d;
  logic [47:0] s2_mag_q, s2_mag_d, s2_na_q;
  logic [31:0] s2_d_q;
  logic [45:0] s1_mag;

  assign s1_mag   = s1_prod_q[45] ? 46'(-s1_prod_q) : 46'(s1_prod_q);
  assign s2_mag_d = {2'b0, s1_mag};

  always_comb begin
    s2_side_d        = '0;
    s2_side_d.ok     = s1_ok_q;
    s2_side_d.col    = s1_col_q;
    s2_side_d.row    = s1_row_q;
    s2_side_d.cx_neg = s1_prod_q[45];
  end

  // first divider span: height and center
  logic [DIV_Q_W-1:0] qa, qb, qc, qd, qe;
  logic [DIV_LAT-1:0] d1_vld_q, d2_vld_q, d3_vld_q;
  sbp_side_t          d1_side_q [DIV_LAT];
  sbp_side_t          d2_side_q [DIV_LAT];
  sbp_side_t          d3_side_q [DIV_LAT];

  sbp_div u_div_height (.clk_i(clk_i), .num_i(s2_na_q),  .den_i(s2_d_q), .quo_o(qa));
  sbp_div u_div_center (.clk_i(clk_i), .num_i(s2_mag_q), .den_i(s2_d_q), .quo_o(qb));

  // stage 3: height floor, center saturation, top edge
  sbp_side_t          d1_out, s3_side_q, s3_side_d;
  logic               s3_vld_q;
  logic signed [17:0] s3_dy_q, s3_dy_d;

  assign d1_out = d1_side_q[DIV_LAT-1];

  always_comb begin
    s3_side_d   = d1_out;
    s3_side_d.h = (qa == '0) ? 16'd1 : qa;
    if (d1_out.cx_neg) begin
      s3_side_d.cx = (qb >= 16'h8000) ? 16'sh8000 : $signed(16'(-qb));
    end else begin
      s3_side_d.cx = (qb >= 16'h7FFF) ? 16'sh7FFF : $signed(qb);
    end
    s3_side_d.top = $signed(18'(cfg.half_screen_height) - 18'(s3_side_d.h >> 1));
    s3_dy_d       = $signed(18'(d1_out.row) - 18'(s3_side_d.top));
  end

  // stage 4: width and texel row numerators
  logic               s4_vld_q;
  sbp_side_t          s4_side_q;
  logic [28:0]        s4_pw_q, s4_pw_d;
  logic signed [31:0] s4_py_q, s4_py_d;
  logic [47:0]        s4_ny;

  assign s4_pw_d = 29'(s3_side_q.h) * 29'(tw_eff);
  assign s4_py_d = 32'(s3_dy_q) * 32'(th_s);
  // a nonpositive numerator maps to texel row zero
  assign s4_ny   = (s4_py_q > 0) ? {16'b0, $unsigned(s4_py_q)} : '0;

  sbp_div u_div_width (
    .clk_i (clk_i),
    .num_i ({19'b0, s4_pw_q}),
    .den_i (32'(th_eff)),
    .quo_o (qc)
  );
  sbp_div u_div_texel_y (
    .clk_i (clk_i),
    .num_i (s4_ny),
    .den_i (32'(s4_side_q.h)),
    .quo_o (qd)
  );

  // stage 5: width floor, texel row clamp, left edge
  sbp_side_t          d2_out, s5_side_q, s5_side_d;
  logic               s5_vld_q;
  logic signed [17:0] s5_dx_q, s5_dx_d;

  assign d2_out = d2_side_q[DIV_LAT-1];

  always_comb begin
    s5_side_d      = d2_out;
    s5_side_d.w    = (qc == '0) ? 16'd1 : qc;
    s5_side_d.ty   = clamp_quo(qd, ty_lim);
    s5_side_d.left = $signed(18'(d2_out.cx) - 18'(s5_side_d.w >> 1));
    s5_dx_d        = $signed(18'(d2_out.col) - 18'(s5_side_d.left));
  end

  // stage 6: texel column numerator
  logic               s6_vld_q;
  sbp_side_t          s6_side_q;
  logic signed [31:0] s6_px_q, s6_px_d;
  logic [47:0]        s6_nx;

  assign s6_px_d = 32'(s5_dx_q) * 32'(tw_s);
  assign s6_nx   = (s6_px_q > 0) ? {16'b0, $unsigned(s6_px_q)} : '0;

  sbp_div u_div_texel_x (
    .clk_i (clk_i),
    .num_i (s6_nx),
    .den_i (32'(s6_side_q.w)),
    .quo_o (qe)
  );

  // stage 7: rectangle clamps and output register
  sbp_side_t          d3_out;
  sbp_res_t           res_q, res_d;
  logic               res_valid_q;
  logic signed [17:0] end_x, end_y;

  assign d3_out = d3_side_q[DIV_LAT-1];
  assign end_x  = $signed(18'(d3_out.cx) + 18'(d3_out.w >> 1));
  assign end_y  = $signed(18'(cfg.half_screen_height) + 18'(d3_out.h >> 1));

  always_comb begin
    res_d = '0;
    if (d3_out.ok) begin
      res_d.valid_res     = 1'b1;
      res_d.center_x      = d3_out.cx;
      res_d.sprite_height = d3_out.h;
      res_d.sprite_width  = d3_out.w;
      res_d.start_x       = clamp_edge(d3_out.left, wx_lim);
      res_d.end_x         = clamp_edge(end_x, wx_lim);
      res_d.start_y       = clamp_edge(d3_out.top, wy_lim);
      res_d.end_y         = clamp_edge(end_y, wy_lim);
      res_d.texel_x       = clamp_quo(qe, tx_lim);
      res_d.texel_y       = d3_out.ty;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q    <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      d1_vld_q    <= '0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      d2_vld_q    <= '0;
      s5_vld_q    <= 1'b0;
      s6_vld_q    <= 1'b0;
      d3_vld_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      s0_vld_q    <= start_i && !busy_o;
      s1_vld_q    <= s0_vld_q;
      s2_vld_q    <= s1_vld_q;
      d1_vld_q    <= {d1_vld_q[DIV_LAT-2:0], s2_vld_q};
      s3_vld_q    <= d1_vld_q[DIV_LAT-1];
      s4_vld_q    <= s3_vld_q;
      d2_vld_q    <= {d2_vld_q[DIV_LAT-2:0], s4_vld_q};
      s5_vld_q    <= d2_vld_q[DIV_LAT-1];
      s6_vld_q    <= s5_vld_q;
      d3_vld_q    <= {d3_vld_q[DIV_LAT-2:0], s6_vld_q};
      res_valid_q <= d3_vld_q[DIV_LAT-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s0_req_q  <= req_i;
    s1_ok_q   <= s1_ok_d;
    s1_col_q  <= s0_req_q.pixel_column;
    s1_row_q  <= s0_req_q.pixel_row;
    s1_d_q    <= $unsigned(s0_req_q.rel_depth);
    s1_prod_q <= s1_prod_d;
    s1_na_q   <= s1_na_d;
    s2_side_q <= s2_side_d;
    s2_mag_q  <= s2_mag_d;
    s2_na_q   <= s1_na_q;
    s2_d_q    <= s1_d_q;
    s3_side_q <= s3_side_d;
    s3_dy_q   <= s3_dy_d;
    s4_side_q <= s3_side_q;
    s4_pw_q   <= s4_pw_d;
    s4_py_q   <= s4_py_d;
    s5_side_q <= s5_side_d;
    s5_dx_q   <= s5_dx_d;
    s6_side_q <= s5_side_q;
    s6_px_q   <= s6_px_d;
    res_q     <= res_d;
    d1_side_q[0] <= s2_side_q;
    d2_side_q[0] <= s4_side_q;
    d3_side_q[0] <= s6_side_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      d1_side_q[k] <= d1_side_q[k-1];
      d2_side_q[k] <= d2_side_q[k-1];
      d3_side_q[k] <= d3_side_q[k-1];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `SBP_ASSERT(a_fixed_latency, start_i && !busy_o |-> ##PIPE_LAT res_valid_o, "result missing")
  `SBP_ASSERT(a_no_spurious, res_valid_o |-> $past(start_i && !busy_o, PIPE_LAT), "extra result")
  `SBP_ASSERT(a_rect_order, res_valid_o && res_o.valid_res |-> res_o.start_x <= res_o.end_x && res_o.start_y <= res_o.end_y, "rect edges swapped")
  `SBP_ASSERT_NEVER(a_size_floor, res_valid_o && res_o.valid_res && (res_o.sprite_height == '0 || res_o.sprite_width == '0), "zero sprite size")

endmodule

/* sv/sbp_cfg.sv */
// configuration register file of the sprite billboard projector
`timescale 1ns / 1ps

module sbp_cfg import sbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output sbp_cfg_t              cfg_o
);

  sbp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (sbp_reg_e'(idx_i))
        REG_PLANE_DIST: cfg_d.plane_distance     = wdata_i;
        REG_HALF_W:     cfg_d.half_screen_width  = wdata_i[11:0];
        REG_HALF_H:     cfg_d.half_screen_height = wdata_i[11:0];
        REG_SCREEN_W:   cfg_d.screen_width       = wdata_i[12:0];
        REG_SCREEN_H:   cfg_d.screen_height      = wdata_i[12:0];
        REG_TEX_W:      cfg_d.texture_width      = wdata_i[12:0];
        REG_TEX_H:      cfg_d.texture_height     = wdata_i[12:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/sbp_div.sv */
// pipelined restoring divider, one quotient bit per stage after the first, quotient saturated
`timescale 1ns / 1ps

module sbp_div import sbp_pkg::*; (
  input  logic               clk_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output logic [DIV_Q_W-1:0] quo_o
);

  logic [DIV_N_W-1:0] rem_q [DIV_LAT];
  logic [DIV_N_W-1:0] rem_d [DIV_LAT];
  logic [DIV_D_W-1:0] den_q [DIV_LAT];
  logic [DIV_D_W-1:0] den_d [DIV_LAT];
  logic [DIV_Q_W-1:0] quo_q [DIV_LAT];
  logic [DIV_Q_W-1:0] quo_d [DIV_LAT];
  logic [DIV_LAT-1:0] ovf_q, ovf_d;
  logic [DIV_N_W-1:0] dsh [1:DIV_Q_W];
  logic [DIV_Q_W:1]   take;

  always_comb begin
    rem_d[0] = num_i;
    den_d[0] = den_i;
    quo_d[0] = '0;
    // quotient would not fit in 16 bits
    ovf_d[0] = num_i >= (DIV_N_W'(den_i) << DIV_Q_W);
    for (int k = 1; k < DIV_LAT; k++) begin
      dsh[k]   = DIV_N_W'(den_q[k-1]) << (DIV_Q_W - k);
      take[k]  = rem_q[k-1] >= dsh[k];
      rem_d[k] = take[k] ? (rem_q[k-1] - dsh[k]) : rem_q[k-1];
      den_d[k] = den_q[k-1];
      ovf_d[k] = ovf_q[k-1];
      quo_d[k] = quo_q[k-1];
      quo_d[k][DIV_Q_W-k] = take[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_LAT; k++) begin
      rem_q[k] <= rem_d[k];
      den_q[k] <= den_d[k];
      quo_q[k] <= quo_d[k];
    end
    ovf_q <= ovf_d;
  end

  assign quo_o = ovf_q[DIV_LAT-1] ? '1 : quo_q[DIV_LAT-1];

endmodule
